@@ rtl/flm_pkg.sv @@
package flm_pkg;

  localparam int ID_W       = 10;
  localparam int TIME_W     = 32;
  localparam int CNT_W      = 16;
  localparam int WIN_W      = 16;
  localparam int USERS_DEF  = 1024;
  localparam int EPOCH_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CNT_W-1:0]   CNT_MAX  = {CNT_W{1'b1}};
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd3;

  // One row of the count memory. A row counts only when vld is set and its
  // epoch matches the current one.
  typedef struct packed {
    logic               vld;
    logic [EPOCH_W-1:0] ep;
    logic [CNT_W-1:0]   cnt;
  } entry_t;

  // Reduce a sender index modulo the table depth by restoring subtraction.
  function automatic logic [ID_W-1:0] mod_users(input logic [ID_W-1:0] id,
                                                input int users);
    int r;
    r = int'(id);
    for (int k = ID_W - 1; k >= 0; k--) begin
      if (r >= (users << k)) begin
        r = r - (users << k);
      end
    end
    return r[ID_W-1:0];
  endfunction

endpackage

@@ rtl/flm_cnt_ram.sv @@
module flm_cnt_ram #(
  parameter int DEPTH = flm_pkg::USERS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output flm_pkg::entry_t    rd_data,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  flm_pkg::entry_t    wr_data
);

  flm_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/per_user_window_flood_limiter_top.sv @@
// Fixed-window flood limiter: one message per clock while start is high and busy is low.
// Each accepted message gives exactly one registered result, shown for one cycle
// with done high; the receiver cannot stall, so results must be taken as they come.
// Per-sender counts live in a single-port-write, registered-read memory; a message reads
// its row on acceptance and a checked one writes it back the next cycle, with the last
// write forwarded so a sender can follow itself back to back. Window resets and writes
// to any register but the enable drop all counts at once by bumping an epoch tag.
// After reset, and after every 256th drop, it sweeps all rows with busy high; while the
// epoch tag sits at its last value it also holds busy for one cycle behind each message.
module per_user_window_flood_limiter_top #(
  parameter int USERS = flm_pkg::USERS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [flm_pkg::ID_W-1:0]          sender_id,
  input  logic [flm_pkg::TIME_W-1:0]        now_secs,
  input  logic                              sender_local,
  input  logic                              sender_operator,
  output logic                              done,
  output logic                              deny,
  output logic [flm_pkg::CNT_W-1:0]         sender_count,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [flm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [flm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int AW = (USERS > 1) ? $clog2(USERS) : 1;

  // configuration
  logic                            limit_enable;
  logic [flm_pkg::CNT_W-1:0]       lines_limit;
  logic [flm_pkg::WIN_W-1:0]       window_secs;
  logic [flm_pkg::TIME_W-1:0]      window_start;

  logic [flm_pkg::TIME_W-1:0]      deadline;
  logic [flm_pkg::EPOCH_W-1:0]     epoch;
  logic                            clearing;
  logic [AW-1:0]                   clr_addr;
  logic                            keep_valid;
  logic [AW-1:0]                   keep_idx;
  flm_pkg::entry_t                 keep_entry;

  // second stage
  logic                            s1_valid;
  logic                            s1_checked;
  logic [AW-1:0]                   s1_idx;
  logic [flm_pkg::TIME_W-1:0]      s1_now;

  logic                            fwd_valid;
  logic [AW-1:0]                   fwd_idx;
  flm_pkg::entry_t                 fwd_entry;

  logic                            accept;
  logic                            cfg_wr;
  logic                            cfg_drop;
  logic [AW-1:0]                   in_idx;
  flm_pkg::entry_t                 rd_data;
  flm_pkg::entry_t                 raw;
  flm_pkg::entry_t                 new_entry;
  flm_pkg::entry_t                 wr_data;
  logic [AW-1:0]                   wr_addr;
  logic                            wr_en;
  logic                            hit;
  logic                            expire;
  logic [flm_pkg::CNT_W-1:0]       cur;
  logic [flm_pkg::CNT_W-1:0]       inc;
  logic                            over;
  logic [flm_pkg::EPOCH_W-1:0]     ep_new;
  logic [flm_pkg::CNT_W-1:0]       pass_cnt;

  logic [flm_pkg::CNT_W-1:0]       limit_next;
  logic [flm_pkg::WIN_W-1:0]       secs_next;
  logic [flm_pkg::TIME_W-1:0]      start_next;

  assign busy      = clearing || (s1_valid && (epoch == flm_pkg::EPOCH_MAX));
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cfg_drop  = cfg_wr && (cfg_index != flm_pkg::CFG_ENABLE);
  assign in_idx    = AW'(flm_pkg::mod_users(sender_id, USERS));

  flm_cnt_ram #(
    .DEPTH(USERS),
    .AW   (AW)
  ) u_ram (
    .clk    (clk),
    .rd_en  (accept),
    .rd_addr(in_idx),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  // Row update for the message in the second stage.
  always_comb begin
    raw    = (fwd_valid && (fwd_idx == s1_idx)) ? fwd_entry : rd_data;
    expire = s1_checked && (s1_now > deadline);
    hit    = raw.vld && (raw.ep == epoch) && !expire;
    cur    = hit ? raw.cnt : '0;
    inc    = (cur != flm_pkg::CNT_MAX) ? cur + 1'b1 : cur;
    over   = (inc >= lines_limit);
    ep_new = expire ? epoch + 1'b1 : epoch;
    pass_cnt = hit ? raw.cnt : '0;
    new_entry.vld = !over;
    new_entry.ep  = ep_new;
    new_entry.cnt = over ? '0 : inc;
  end

  always_comb begin
    if (clearing) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      // put back the row written by the message that wrapped the epoch
      wr_data = (keep_valid && (clr_addr == keep_idx)) ? keep_entry : '0;
    end else begin
      wr_en   = s1_valid && s1_checked;
      wr_addr = s1_idx;
      wr_data = new_entry;
    end
  end

  always_comb begin
    limit_next = lines_limit;
    secs_next  = window_secs;
    start_next = window_start;
    unique case (cfg_index)
      flm_pkg::CFG_ENABLE: ;
      flm_pkg::CFG_LIMIT:  limit_next = cfg_data[flm_pkg::CNT_W-1:0];
      flm_pkg::CFG_WINDOW: secs_next  = cfg_data[flm_pkg::WIN_W-1:0];
      flm_pkg::CFG_START:  start_next = cfg_data[flm_pkg::TIME_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_enable <= 1'b0;
      lines_limit  <= flm_pkg::CNT_W'(2);
      window_secs  <= flm_pkg::WIN_W'(1);
      window_start <= '0;
    end else if (cfg_wr) begin
      if (cfg_index == flm_pkg::CFG_ENABLE) begin
        limit_enable <= cfg_data[0];
      end
      lines_limit  <= limit_next;
      window_secs  <= secs_next;
      window_start <= start_next;
    end
  end

  // Epoch, deadline and the sweep that retires old tags before they come round.
  always_ff @(posedge clk) begin
    if (rst) begin
      deadline   <= flm_pkg::TIME_W'(1);
      epoch      <= '0;
      clearing   <= 1'b1;
      clr_addr   <= '0;
      keep_valid <= 1'b0;
      keep_idx   <= '0;
      keep_entry <= '0;
    end else begin
      priority if (cfg_drop) begin
        deadline   <= start_next + flm_pkg::TIME_W'(secs_next);
        epoch      <= epoch + 1'b1;
        keep_valid <= 1'b0;
        if (epoch == flm_pkg::EPOCH_MAX) begin
          clearing <= 1'b1;
          clr_addr <= '0;
        end else if (clearing && (clr_addr == AW'(USERS - 1))) begin
          clearing <= 1'b0;
        end else if (clearing) begin
          clr_addr <= clr_addr + 1'b1;
        end
      end else if (clearing) begin
        if (clr_addr == AW'(USERS - 1)) begin
          clearing <= 1'b0;
        end else begin
          clr_addr <= clr_addr + 1'b1;
        end
      end else if (s1_valid && expire) begin
        deadline <= s1_now + flm_pkg::TIME_W'(window_secs);
        epoch    <= ep_new;
        if (epoch == flm_pkg::EPOCH_MAX) begin
          clearing   <= 1'b1;
          clr_addr   <= '0;
          keep_valid <= 1'b1;
          keep_idx   <= s1_idx;
          keep_entry <= new_entry;
        end
      end else begin
        deadline <= deadline;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      s1_valid  <= accept;
      fwd_valid <= !clearing && s1_valid && s1_checked;
      done      <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_idx     <= in_idx;
      s1_now     <= now_secs;
      s1_checked <= limit_enable && sender_local && !sender_operator;
    end
    fwd_idx   <= s1_idx;
    fwd_entry <= new_entry;
    if (s1_valid) begin
      if (s1_checked) begin
        deny         <= over;
        sender_count <= new_entry.cnt;
      end else begin
        deny         <= 1'b0;
        sender_count <= pass_cnt;
      end
    end
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int USERS_N    = flm_pkg::USERS_DEF;
  localparam int DIR_ROWS   = 28;
  localparam int SEGMENTS   = 6;
  localparam int SEG_ITEMS  = 185;
  localparam int POOL_N     = 8;
  localparam int CYCLE_CAP  = 200000;

  typedef enum logic {ROW_REG, ROW_MSG} row_kind_t;
  typedef enum logic {BY_PREDICTOR, TYPED_IN} check_src_t;

  typedef struct packed {
    row_kind_t                      kind;
    logic [flm_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [flm_pkg::CFG_DATA_W-1:0] reg_data;
    logic [flm_pkg::ID_W-1:0]       id;
    logic [flm_pkg::TIME_W-1:0]     now;
    logic                           loc;
    logic                           op;
    check_src_t                     src;
    logic                           want_deny;
    logic [flm_pkg::CNT_W-1:0]      want_count;
  } row_t;

  typedef struct packed {
    logic                      deny;
    logic [flm_pkg::CNT_W-1:0] count;
  } verdict_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           start = 1'b0;
  logic                           busy;
  logic [flm_pkg::ID_W-1:0]       sender_id = '0;
  logic [flm_pkg::TIME_W-1:0]     now_secs = '0;
  logic                           sender_local = 1'b0;
  logic                           sender_operator = 1'b0;
  logic                           done;
  logic                           deny;
  logic [flm_pkg::CNT_W-1:0]      sender_count;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [flm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [flm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  per_user_window_flood_limiter_top DUT (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .sender_id       (sender_id),
    .now_secs        (now_secs),
    .sender_local    (sender_local),
    .sender_operator (sender_operator),
    .done            (done),
    .deny            (deny),
    .sender_count    (sender_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #2 clk = ~clk;

  // Limiter state as the block should hold it
  logic                           lim_en = 1'b0;
  logic [flm_pkg::CNT_W-1:0]      lim_lines = 16'd2;
  logic [flm_pkg::WIN_W-1:0]      win_len = 16'd1;
  logic [flm_pkg::TIME_W-1:0]     win_base = '0;
  logic [flm_pkg::TIME_W-1:0]     win_deadline = 32'd1;
  logic [USERS_N-1:0]             cnt_live = '0;
  logic [flm_pkg::CNT_W-1:0]      cnt_store [USERS_N];

  verdict_t pending_verdicts [$];

  int gap_pct = 17;
  int fail_count = 0;
  int items_sent = 0;
  int bypassed = 0;
  int denied = 0;
  int rollovers = 0;
  int reg_writes = 0;
  int results_checked = 0;
  int cycle_count = 0;

  function automatic verdict_t limiter_predict(input logic [flm_pkg::ID_W-1:0] id,
                                               input logic [flm_pkg::TIME_W-1:0] now,
                                               input logic loc, input logic op);
    verdict_t v;
    int slot;
    logic [flm_pkg::CNT_W:0] next;
    slot = int'(id) % USERS_N;
    v.deny = 1'b0;
    if (!lim_en || !loc || op) begin
      v.count = cnt_live[slot] ? cnt_store[slot] : '0;
      bypassed++;
      return v;
    end
    if (now > win_deadline) begin
      cnt_live = '0;
      win_deadline = now + {16'd0, win_len};
      rollovers++;
    end
    next = cnt_live[slot] ? {1'b0, cnt_store[slot]} : '0;
    if (next < {1'b0, flm_pkg::CNT_MAX}) next = next + 1'b1;
    if (next >= {1'b0, lim_lines}) begin
      cnt_live[slot] = 1'b0;
      v.deny = 1'b1;
      v.count = '0;
      denied++;
    end else begin
      cnt_store[slot] = next[flm_pkg::CNT_W-1:0];
      cnt_live[slot] = 1'b1;
      v.count = next[flm_pkg::CNT_W-1:0];
    end
    return v;
  endfunction

  function automatic void limiter_write_reg(input logic [flm_pkg::CFG_IDX_W-1:0] idx,
                                            input logic [flm_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      flm_pkg::CFG_ENABLE: lim_en = data[0];
      flm_pkg::CFG_LIMIT:  lim_lines = data[flm_pkg::CNT_W-1:0];
      flm_pkg::CFG_WINDOW: win_len = data[flm_pkg::WIN_W-1:0];
      flm_pkg::CFG_START:  win_base = data;
      default: ;
    endcase
    // every register but the enable restarts the window
    if (idx != flm_pkg::CFG_ENABLE) begin
      cnt_live = '0;
      win_deadline = win_base + {16'd0, win_len};
    end
  endfunction

  function automatic row_t reg_row(input logic [flm_pkg::CFG_IDX_W-1:0] idx,
                                   input logic [flm_pkg::CFG_DATA_W-1:0] data);
    row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.reg_idx = idx;
    r.reg_data = data;
    return r;
  endfunction

  function automatic row_t msg_row(input logic [flm_pkg::ID_W-1:0] id,
                                   input logic [flm_pkg::TIME_W-1:0] now,
                                   input logic loc, input logic op, input check_src_t src,
                                   input logic d, input logic [flm_pkg::CNT_W-1:0] c);
    row_t r;
    r = '0;
    r.kind = ROW_MSG;
    r.id = id;
    r.now = now;
    r.loc = loc;
    r.op = op;
    r.src = src;
    r.want_deny = d;
    r.want_count = c;
    return r;
  endfunction

  // Leaves start high after the accepting edge; the caller drives the next
  // item or lowers start in the same step.
  task automatic send_msg(input logic [flm_pkg::ID_W-1:0] id,
                          input logic [flm_pkg::TIME_W-1:0] now,
                          input logic loc, input logic op, input check_src_t src,
                          input logic d, input logic [flm_pkg::CNT_W-1:0] c);
    verdict_t v;
    if ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    sender_id <= id;
    now_secs <= now;
    sender_local <= loc;
    sender_operator <= op;
    @(posedge clk);
    while (busy) @(posedge clk);
    v = limiter_predict(id, now, loc, op);
    if (src == TYPED_IN) begin
      v.deny = d;
      v.count = c;
    end
    pending_verdicts.push_back(v);
    items_sent++;
  endtask

  // Hold valid high when another write follows in the same burst
  task automatic write_reg(input logic [flm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [flm_pkg::CFG_DATA_W-1:0] data, input bit more);
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (!more) cfg_valid <= 1'b0;
    limiter_write_reg(idx, data);
    reg_writes++;
  endtask

  always @(posedge clk) begin : watch_results
    verdict_t want;
    if (!rst && done) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual deny %0d count %0d",
                 $time, deny, sender_count);
        fail_count++;
      end else begin
        want = pending_verdicts.pop_front();
        results_checked++;
        if (deny !== want.deny) begin
          $display("%0t: deny mismatch, expected %0d actual %0d", $time, want.deny, deny);
          fail_count++;
        end
        if (sender_count !== want.count) begin
          $display("%0t: sender_count mismatch, expected %0d actual %0d",
                   $time, want.count, sender_count);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_verdicts.size());
      $display("** per_user_window_flood_limiter_top: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    row_t rows [DIR_ROWS];
    logic [flm_pkg::ID_W-1:0] pool [POOL_N];
    logic [flm_pkg::TIME_W-1:0] tsec;
    logic [flm_pkg::TIME_W-1:0] now;
    logic [flm_pkg::CFG_DATA_W-1:0] st;
    logic [flm_pkg::WIN_W-1:0] win;
    logic [flm_pkg::CNT_W-1:0] lim;
    logic [flm_pkg::ID_W-1:0] id;
    logic en;
    logic loc;
    logic op;
    int pick;

    rows = '{
      msg_row(10'd0,    32'h0000_0000, 1'b1, 1'b0, TYPED_IN, 1'b0, 16'd0),
      msg_row(10'd1023, 32'hFFFF_FFFF, 1'b1, 1'b0, TYPED_IN, 1'b0, 16'd0),
      msg_row(10'd512,  32'h5555_AAAA, 1'b0, 1'b1, BY_PREDICTOR, 1'b0, 16'd0),
      reg_row(flm_pkg::CFG_ENABLE, 32'd1),
      msg_row(10'd5,    32'd0, 1'b1, 1'b0, TYPED_IN, 1'b0, 16'd1),
      msg_row(10'd5,    32'd1, 1'b1, 1'b0, TYPED_IN, 1'b1, 16'd0),
      msg_row(10'd5,    32'd1, 1'b1, 1'b1, TYPED_IN, 1'b0, 16'd0),
      msg_row(10'd5,    32'd1, 1'b1, 1'b0, TYPED_IN, 1'b0, 16'd1),
      msg_row(10'd5,    32'd2, 1'b0, 1'b0, TYPED_IN, 1'b0, 16'd1),
      msg_row(10'd5,    32'd2, 1'b1, 1'b0, TYPED_IN, 1'b0, 16'd1),
      // upper bits of a 16-bit register are dropped
      reg_row(flm_pkg::CFG_LIMIT, 32'hFFFF_FFFF),
      msg_row(10'd1023, 32'd0, 1'b1, 1'b0, TYPED_IN, 1'b0, 16'd1),
      msg_row(10'd1023, 32'd0, 1'b1, 1'b0, TYPED_IN, 1'b0, 16'd2),
      msg_row(10'd1023, 32'd0, 1'b0, 1'b1, TYPED_IN, 1'b0, 16'd2),
      reg_row(flm_pkg::CFG_WINDOW, 32'h0000_FFFF),
      // deadline wraps past zero
      reg_row(flm_pkg::CFG_START, 32'hFFFF_FFF0),
      msg_row(10'd0,    32'hFFFF_FFFF, 1'b1, 1'b0, TYPED_IN, 1'b0, 16'd1),
      msg_row(10'd0,    32'h0000_FFFE, 1'b1, 1'b0, TYPED_IN, 1'b0, 16'd2),
      msg_row(10'd0,    32'h0000_FFFF, 1'b1, 1'b0, TYPED_IN, 1'b0, 16'd1),
      // a limit below two denies every checked message
      reg_row(flm_pkg::CFG_LIMIT, 32'd1),
      msg_row(10'd3,    32'h0001_0000, 1'b1, 1'b0, TYPED_IN, 1'b1, 16'd0),
      msg_row(10'd3,    32'h0001_0000, 1'b1, 1'b1, TYPED_IN, 1'b0, 16'd0),
      reg_row(flm_pkg::CFG_LIMIT, 32'd0),
      msg_row(10'd2,    32'h0001_0000, 1'b1, 1'b0, TYPED_IN, 1'b1, 16'd0),
      reg_row(flm_pkg::CFG_ENABLE, 32'hFFFF_FFFE),
      msg_row(10'd2,    32'h0001_0000, 1'b1, 1'b0, TYPED_IN, 1'b0, 16'd0),
      reg_row(flm_pkg::CFG_ENABLE, 32'hFFFF_FFFF),
      msg_row(10'd682,  32'hAAAA_5555, 1'b1, 1'b0, BY_PREDICTOR, 1'b0, 16'd0)
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REG) begin
        write_reg(rows[i].reg_idx, rows[i].reg_data,
                  i + 1 < DIR_ROWS && rows[i + 1].kind == ROW_REG);
      end else begin
        send_msg(rows[i].id, rows[i].now, rows[i].loc, rows[i].op, rows[i].src,
                 rows[i].want_deny, rows[i].want_count);
      end
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      gap_pct = (seg < 2) ? 17 : (seg < 4) ? 67 : 0;
      case (seg)
        0: begin en = 1'b1; lim = 16'd3; win = 16'd5; st = $urandom(); end
        1: begin en = 1'b1; lim = flm_pkg::CNT_MAX; win = 16'hFFFF; st = 32'hFFFF_FFF0; end
        2: begin en = 1'b1; lim = 16'd2; win = 16'd1; st = $urandom(); end
        3: begin
          en = 1'b1;
          lim = 16'($urandom_range(2, 6));
          win = 16'($urandom_range(1, 30));
          st = $urandom();
        end
        4: begin
          en = ($urandom_range(0, 3) != 0);
          lim = 16'($urandom_range(2, 40));
          win = 16'($urandom_range(1, 65535));
          st = $urandom();
        end
        default: begin
          en = 1'b1;
          lim = 16'd4;
          win = 16'($urandom_range(1, 8));
          st = 32'hFFFF_FFE0;
        end
      endcase
      // junk in the unused upper bits must be ignored
      write_reg(flm_pkg::CFG_ENABLE, {31'($urandom()), en}, 1'b1);
      write_reg(flm_pkg::CFG_LIMIT, {16'($urandom()), lim}, 1'b1);
      write_reg(flm_pkg::CFG_WINDOW, {16'($urandom()), win}, 1'b1);
      write_reg(flm_pkg::CFG_START, st, 1'b0);

      foreach (pool[k]) pool[k] = flm_pkg::ID_W'($urandom_range(0, 1023));
      tsec = st;
      for (int n = 0; n < SEG_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        now = tsec;
        if (pick < 80) begin
          id = pool[$urandom_range(0, POOL_N - 1)];
          loc = 1'b1;
          op = 1'b0;
        end else begin
          id = (pick < 90) ? pool[$urandom_range(0, POOL_N - 1)]
                           : flm_pkg::ID_W'($urandom_range(0, 1023));
          op = 1'($urandom_range(0, 1));
          loc = 1'($urandom_range(0, 1));
          // random time only where it cannot move the window
          if (!loc || op) now = $urandom();
        end
        if ($urandom_range(0, 3) == 0) tsec = tsec + 1;
        if ($urandom_range(0, 39) == 0) tsec = tsec + win + $urandom_range(1, 3);
        send_msg(id, now, loc, op, BY_PREDICTOR, 1'b0, '0);
      end
    end

    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run sent %0d messages (%0d bypassed, %0d denied), %0d register writes,",
             items_sent, bypassed, denied, reg_writes);
    $display("%0d window rollovers, %0d results checked, %0d mismatches.",
             rollovers, results_checked, fail_count);
    if (fail_count == 0) begin
      $display("** per_user_window_flood_limiter_top: PASSED **");
    end else begin
      $display("** per_user_window_flood_limiter_top: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/flm_pkg.sv
rtl/flm_cnt_ram.sv
rtl/per_user_window_flood_limiter_top.sv
dv/testbench.sv
